/* rtl/i2cm_pkg.sv */
package i2cm_pkg;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_IDLEBUS = 3'd1,
		CMD_START   = 3'd2,
		CMD_STOP    = 3'd3,
		CMD_WRITE   = 3'd4,
		CMD_READ    = 3'd5
	} cmd_t;

	localparam int unsigned CFG_WIDTH = 16;
	localparam logic [CFG_WIDTH-1:0] HALF_PERIOD_RESET = 16'd250;

	localparam logic [4:0] SEGS_IDLEBUS = 5'd1;
	localparam logic [4:0] SEGS_EDGE    = 5'd3;
	localparam logic [4:0] SEGS_BYTE    = 5'd19;

	// Phases of a byte transfer that carry special meaning.
	localparam logic [4:0] PH_ACK_SETUP = 5'd16;
	localparam logic [4:0] PH_ACK_HIGH  = 5'd17;
	localparam logic [4:0] PH_ACK_LOW   = 5'd18;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} fq_t;

endpackage

/* rtl/i2cm_if.sv */
interface i2cm_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, cmd, tx_byte, send_ack, sda_in, input ready);
	modport sink (input valid, cmd, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_release;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;
	logic       cmd_rejected;

	modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
		ack_seen, cmd_rejected, input ready);
	modport sink (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
		ack_seen, cmd_rejected, output ready);
endinterface

interface i2cm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/i2cm_front.sv */
module i2cm_front (
	input  logic         clk,
	input  logic         arst_n,
	i2cm_req_if.sink     req,
	output i2cm_pkg::fq_t fq,
	input  logic         pop
);
	import i2cm_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cls;

	// Codes beyond the command range are treated as no command.
	assign cls = (req.cmd > 3'(CMD_READ)) ? CMD_NONE : cmd_t'(req.cmd);

	assign req.ready = (count_q != 2'd2);
	assign push      = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{cmd: cls, tx_byte: req.tx_byte, send_ack: req.send_ack,
				sda_in: req.sda_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign fq.valid = (count_q != 2'd0);
	assign fq.entry = mem_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 && !pop |=> count_q == 2'd2)
		else $error("queue lost or gained a word while full");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("pop from empty queue");
endmodule

/* rtl/i2cm_back.sv */
module i2cm_back #(
	parameter int unsigned DIVIDER_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  i2cm_pkg::fq_t fq,
	output logic          pop,
	i2cm_cfg_if.sink      cfg,
	i2cm_rsp_if.source    rsp
);
	import i2cm_pkg::*;

	localparam int unsigned DW = DIVIDER_WIDTH;
	localparam logic [DW-1:0] MAX_CNT = '1;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic [7:0] shift;
	} pins_t;

	function automatic logic [4:0] seg_count(cmd_t c);
		logic [4:0] n;
		unique case (c)
			CMD_IDLEBUS: n = SEGS_IDLEBUS;
			CMD_START, CMD_STOP: n = SEGS_EDGE;
			default: n = SEGS_BYTE;
		endcase
		return n;
	endfunction

	function automatic pins_t seg_enter(cmd_t c, logic [4:0] s, pins_t p, logic mack);
		pins_t      r;
		logic [4:0] t;
		r = p;
		t = s - 5'd1;
		unique case (c)
			CMD_IDLEBUS: begin
				r.scl = 1'b1;
				r.sda = 1'b1;
			end
			CMD_START: begin
				if (s == 5'd0) begin
					r.scl = 1'b1;
					r.sda = 1'b1;
				end else if (s == 5'd1) begin
					r.sda = 1'b0;
				end else begin
					r.scl = 1'b0;
				end
			end
			CMD_STOP: begin
				if (s == 5'd0) r.sda = 1'b0;
				else if (s == 5'd1) r.scl = 1'b1;
				else r.sda = 1'b1;
			end
			CMD_WRITE: begin
				if (s < PH_ACK_SETUP) begin
					if (!s[0]) begin
						// The first bit leaves SCL as the previous command left it.
						if (s != 5'd0) r.scl = 1'b0;
						r.sda   = p.shift[7];
						r.shift = {p.shift[6:0], 1'b0};
					end else begin
						r.scl = 1'b1;
					end
				end else if (s == PH_ACK_SETUP) begin
					r.scl = 1'b0;
					r.sda = 1'b1;
				end else if (s == PH_ACK_HIGH) begin
					r.scl = 1'b1;
				end else begin
					r.scl = 1'b0;
				end
			end
			default: begin
				if (s == 5'd0) begin
					r.sda = 1'b1;
				end else if (s <= PH_ACK_SETUP) begin
					if (!t[0]) begin
						r.scl = 1'b1;
					end else begin
						r.scl = 1'b0;
						if (t[4:1] == 4'd7) r.sda = !mack;
					end
				end else if (s == PH_ACK_HIGH) begin
					r.scl = 1'b1;
				end else begin
					r.scl = 1'b0;
					r.sda = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	logic [CFG_WIDTH-1:0] hp_q;
	logic [CFG_WIDTH-1:0] hp_nz;
	logic [DW-1:0]        target;

	cmd_t       act_q;
	logic [4:0] phase_q;
	logic [DW-1:0] div_q;
	logic [7:0] shift_q;
	logic       scl_q;
	logic       sda_q;
	logic       ack_q;
	logic       mack_q;
	logic [7:0] rx_q;

	logic       out_valid_q;
	logic       out_done_q;
	logic       out_rej_q;

	cmd_t       n_act;
	logic [4:0] n_phase;
	logic [DW-1:0] n_div;
	logic [DW-1:0] div_inc;
	logic       n_ack;
	logic       n_mack;
	logic [7:0] n_rx;
	logic       rej;
	logic       done;
	pins_t      pins;
	entry_t     e;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= HALF_PERIOD_RESET;
		end else if (cfg.valid) begin
			hp_q <= cfg.data;
		end
	end

	// A half period of zero counts as one tick; a value beyond the divider saturates.
	assign hp_nz = (hp_q == '0) ? CFG_WIDTH'(1) : hp_q;

	if (DW >= CFG_WIDTH) begin : g_wide
		assign target = DW'(hp_nz);
	end else begin : g_narrow
		assign target = (hp_nz > CFG_WIDTH'(MAX_CNT)) ? MAX_CNT : DW'(hp_nz);
	end

	assign e   = fq.entry;
	assign pop = fq.valid && (!out_valid_q || rsp.ready);

	always_comb begin
		n_act   = act_q;
		n_phase = phase_q;
		n_div   = div_q;
		n_ack   = ack_q;
		n_mack  = mack_q;
		n_rx    = rx_q;
		rej     = 1'b0;
		done    = 1'b0;
		pins    = '{scl: scl_q, sda: sda_q, shift: shift_q};
		div_inc = div_q + DW'(1);
		if (act_q != CMD_NONE) begin
			rej = (e.cmd != CMD_NONE);
			if (div_inc >= target) begin
				n_div = '0;
				// Sample the line at the end of the segment.
				if (act_q == CMD_WRITE && phase_q == PH_ACK_HIGH) n_ack = !e.sda_in;
				if (act_q == CMD_READ) begin
					if (phase_q != 5'd0 && phase_q <= PH_ACK_SETUP && phase_q[0]) begin
						pins.shift = {shift_q[6:0], e.sda_in};
					end
					if (phase_q == PH_ACK_LOW) n_rx = shift_q;
				end
				n_phase = phase_q + 5'd1;
				if (n_phase >= seg_count(act_q)) begin
					n_act   = CMD_NONE;
					n_phase = 5'd0;
					done    = 1'b1;
				end else begin
					pins = seg_enter(act_q, n_phase, pins, mack_q);
				end
			end else begin
				n_div = div_inc;
			end
		end else if (e.cmd != CMD_NONE) begin
			n_act   = e.cmd;
			n_phase = 5'd0;
			n_div   = '0;
			if (e.cmd == CMD_WRITE) pins.shift = e.tx_byte;
			if (e.cmd == CMD_READ) begin
				pins.shift = 8'd0;
				n_mack     = e.send_ack;
			end
			pins = seg_enter(e.cmd, 5'd0, pins, n_mack);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= CMD_NONE;
			phase_q     <= 5'd0;
			div_q       <= '0;
			shift_q     <= 8'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b0;
			mack_q      <= 1'b0;
			rx_q        <= 8'd0;
			out_valid_q <= 1'b0;
			out_done_q  <= 1'b0;
			out_rej_q   <= 1'b0;
		end else begin
			if (pop) begin
				act_q      <= n_act;
				phase_q    <= n_phase;
				div_q      <= n_div;
				shift_q    <= pins.shift;
				scl_q      <= pins.scl;
				sda_q      <= pins.sda;
				ack_q      <= n_ack;
				mack_q     <= n_mack;
				rx_q       <= n_rx;
				out_done_q <= done;
				out_rej_q  <= rej;
			end
			if (pop) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.scl_level    = scl_q;
	assign rsp.sda_release  = sda_q;
	assign rsp.busy_res     = (act_q != CMD_NONE);
	assign rsp.done_res     = out_done_q;
	assign rsp.rx_byte      = rx_q;
	assign rsp.ack_seen     = ack_q;
	assign rsp.cmd_rejected = out_rej_q;

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		pop && act_q != CMD_NONE && fq.entry.cmd != CMD_NONE |=> out_rej_q)
		else $error("command while busy was not flagged");
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		act_q == CMD_NONE |-> phase_q == 5'd0 && div_q == '0)
		else $error("idle engine holds a phase or count");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		act_q != CMD_NONE |-> phase_q < seg_count(act_q))
		else $error("segment index beyond the sequence");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop && act_q != CMD_NONE && n_act == CMD_NONE |=> out_done_q && act_q == CMD_NONE)
		else $error("sequence ended without a done word");
endmodule

/* rtl/i2c_master_byte_engine.sv */
// I2C master byte engine, standard mode, stepped by system ticks.
// The req channel carries one word per system tick: a command (none, bus idle,
// start, stop, write byte, read byte), the byte to send, the ACK choice for a
// read and the sampled SDA level. The rsp channel returns exactly one word per
// req word, in order: SCL level, SDA release, busy, done, last read byte, last
// ACK seen and a flag for a command that arrived while busy.
// The cfg channel writes the SCL half period in ticks; write it while idle.
// Throughput is one word per cycle while rsp is not stalled. A word accepted
// into the two-entry front queue is executed by the back engine when popped,
// and its result is presented from the output register. The engine state
// steps only when a queued word is executed, so stalls change no bus timing
// in ticks. When rsp is stalled the output register holds; the queue takes
// up to two more words and then drops req ready until the receiver drains it.
// Reset clears the queue and returns the engine to idle with SCL high, SDA
// released, a half period of 250 ticks and a cleared read byte and ACK.
module i2c_master_byte_engine #(
	parameter int unsigned DIVIDER_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	i2cm_req_if.sink   req,
	i2cm_rsp_if.source rsp,
	i2cm_cfg_if.sink   cfg
);
	import i2cm_pkg::*;

	fq_t  fq;
	logic pop;

	i2cm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.fq     (fq),
		.pop    (pop)
	);

	i2cm_back #(
		.DIVIDER_WIDTH (DIVIDER_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fq     (fq),
		.pop    (pop),
		.cfg    (cfg),
		.rsp    (rsp)
	);
endmodule

/* tb/sv/tb.sv */
module tb;
	import i2cm_pkg::*;

	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;
	localparam int SDA_LOW = 0;
	localparam int SDA_HIGH = 1;
	localparam int SDA_RAND = 2;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int LIMIT_CYCLES = 2_000_000;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
		logic       cmd_rejected;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	i2cm_req_if req_ch();
	i2cm_rsp_if rsp_ch();
	i2cm_cfg_if cfg_ch();

	i2c_master_byte_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Engine state as the bus master should hold it.
	logic [2:0]  active_op = CMD_NONE;
	logic [4:0]  seg_idx = '0;
	logic [15:0] div_cnt = '0;
	logic [7:0]  shreg = '0;
	logic        scl_q = 1'b1;
	logic        sda_q = 1'b1;
	logic        ack_q = 1'b0;
	logic        ack_choice = 1'b0;
	logic [7:0]  rx_last = '0;
	logic [15:0] half_ticks = HALF_PERIOD_RESET;

	entry_t       tick_q[$];
	tick_result_t pending_results[$];
	entry_t       held_word;
	bit           word_held = 1'b0;
	bit           word_taken = 1'b0;
	int           send_gap = 0;
	int           rsp_stall = 0;
	int           hold_req = 0;
	int           hold_seen = 0;
	bit           no_idle = 1'b0;
	int           ticks_pushed = 0;
	int           err_count = 0;

	function automatic int segs_of(logic [2:0] op);
		if (op == CMD_IDLEBUS)
			return int'(SEGS_IDLEBUS);
		if (op == CMD_START || op == CMD_STOP)
			return int'(SEGS_EDGE);
		return int'(SEGS_BYTE);
	endfunction

	function automatic void enter_segment(logic [2:0] op, logic [4:0] s);
		case (op)
			CMD_IDLEBUS: begin
				sda_q = 1'b1;
				scl_q = 1'b1;
			end
			CMD_START: begin
				if (s == 0) begin
					sda_q = 1'b1;
					scl_q = 1'b1;
				end else if (s == 1)
					sda_q = 1'b0;
				else
					scl_q = 1'b0;
			end
			CMD_STOP: begin
				if (s == 0)
					sda_q = 1'b0;
				else if (s == 1)
					scl_q = 1'b1;
				else
					sda_q = 1'b1;
			end
			CMD_WRITE: begin
				if (s < PH_ACK_SETUP) begin
					// Even phases put the next data bit out; the very first one leaves SCL alone.
					if (!s[0]) begin
						if (s != 0)
							scl_q = 1'b0;
						sda_q = shreg[7];
						shreg = {shreg[6:0], 1'b0};
					end else
						scl_q = 1'b1;
				end else if (s == PH_ACK_SETUP) begin
					scl_q = 1'b0;
					sda_q = 1'b1;
				end else if (s == PH_ACK_HIGH)
					scl_q = 1'b1;
				else
					scl_q = 1'b0;
			end
			default: begin
				if (s == 0)
					sda_q = 1'b1;
				else if (s <= PH_ACK_SETUP) begin
					if (s[0])
						scl_q = 1'b1;
					else begin
						scl_q = 1'b0;
						if (s == PH_ACK_SETUP)
							sda_q = !ack_choice;
					end
				end else if (s == PH_ACK_HIGH)
					scl_q = 1'b1;
				else begin
					scl_q = 1'b0;
					sda_q = 1'b1;
				end
			end
		endcase
	endfunction

	function automatic void leave_segment(logic [2:0] op, logic [4:0] s, logic sda);
		if (op == CMD_WRITE && s == PH_ACK_HIGH)
			ack_q = !sda;
		if (op == CMD_READ) begin
			if (s >= 1 && s <= PH_ACK_SETUP && s[0])
				shreg = {shreg[6:0], sda};
			if (s == PH_ACK_LOW)
				rx_last = shreg;
		end
	endfunction

	function automatic tick_result_t step_engine(entry_t w);
		tick_result_t r;
		logic [2:0]   op;
		logic [15:0]  target;
		bit           is_cmd;
		op = w.cmd;
		is_cmd = (op >= CMD_IDLEBUS && op <= CMD_READ);
		target = (half_ticks == 0) ? 16'd1 : half_ticks;
		r.done_res = 1'b0;
		r.cmd_rejected = 1'b0;
		if (active_op != CMD_NONE) begin
			r.cmd_rejected = is_cmd;
			div_cnt = div_cnt + 16'd1;
			if (div_cnt >= target) begin
				div_cnt = '0;
				leave_segment(active_op, seg_idx, w.sda_in);
				seg_idx = seg_idx + 5'd1;
				if (seg_idx >= segs_of(active_op)) begin
					active_op = CMD_NONE;
					seg_idx = '0;
					r.done_res = 1'b1;
				end else
					enter_segment(active_op, seg_idx);
			end
		end else if (is_cmd) begin
			active_op = op;
			seg_idx = '0;
			div_cnt = '0;
			if (op == CMD_WRITE)
				shreg = w.tx_byte;
			if (op == CMD_READ) begin
				shreg = '0;
				ack_choice = w.send_ack;
			end
			enter_segment(op, 5'd0);
		end
		r.scl_level = scl_q;
		r.sda_release = sda_q;
		r.busy_res = (active_op != CMD_NONE);
		r.rx_byte = rx_last;
		r.ack_seen = ack_q;
		return r;
	endfunction

	function automatic void cmp_field(string fname, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			err_count++;
		end
	endfunction

	always @(posedge clk) begin : watch
		entry_t       w;
		tick_result_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				w.cmd = cmd_t'(req_ch.cmd);
				w.tx_byte = req_ch.tx_byte;
				w.send_ack = req_ch.send_ack;
				w.sda_in = req_ch.sda_in;
				pending_results.push_back(step_engine(w));
				word_taken = 1'b1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result word arrived with nothing expected");
					err_count++;
				end else begin
					want = pending_results.pop_front();
					cmp_field("scl_level", want.scl_level, rsp_ch.scl_level);
					cmp_field("sda_release", want.sda_release, rsp_ch.sda_release);
					cmp_field("busy_res", want.busy_res, rsp_ch.busy_res);
					cmp_field("done_res", want.done_res, rsp_ch.done_res);
					cmp_field("rx_byte", want.rx_byte, rsp_ch.rx_byte);
					cmp_field("ack_seen", want.ack_seen, rsp_ch.ack_seen);
					cmp_field("cmd_rejected", want.cmd_rejected, rsp_ch.cmd_rejected);
				end
			end
		end
	end

	// A word stays on the bus until it is taken; gaps only open between words.
	always @(negedge clk) begin
		if (arst_n) begin
			if (word_taken) begin
				word_held = 1'b0;
				word_taken = 1'b0;
			end
			if (!word_held) begin
				if (send_gap > 0)
					send_gap--;
				else if (!no_idle && $urandom_range(0, 15) == 0)
					send_gap = $urandom_range(0, 18);
				else if (tick_q.size() > 0) begin
					held_word = tick_q.pop_front();
					word_held = 1'b1;
				end
			end
			req_ch.valid <= word_held;
			req_ch.cmd <= held_word.cmd;
			req_ch.tx_byte <= held_word.tx_byte;
			req_ch.send_ack <= held_word.send_ack;
			req_ch.sda_in <= held_word.sda_in;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				rsp_stall = LONG_HOLD_CYCLES;
			end
			if (rsp_stall > 0) begin
				rsp_stall--;
				rsp_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 15) == 0) begin
				rsp_stall = $urandom_range(0, 18);
				rsp_ch.ready <= 1'b0;
			end else
				rsp_ch.ready <= 1'b1;
		end
	end

	function automatic logic pick_sda(int mode);
		if (mode == SDA_RAND)
			return 1'($urandom_range(0, 1));
		return (mode == SDA_HIGH);
	endfunction

	task automatic push_tick(logic [2:0] op, logic [7:0] b, logic a, logic s);
		entry_t w;
		w.cmd = cmd_t'(op);
		w.tx_byte = b;
		w.send_ack = a;
		w.sda_in = s;
		tick_q.push_back(w);
		ticks_pushed++;
	endtask

	// One command and exactly the ticks it needs; the done tick is the last one pushed.
	task automatic run_command(cmd_t op, logic [7:0] b, logic a, int sda_mode, bit noisy);
		int         span;
		logic [2:0] extra;
		span = segs_of(op) * ((half_ticks == 0) ? 1 : int'(half_ticks));
		push_tick(op, b, a, pick_sda(sda_mode));
		for (int k = 1; k <= span; k++) begin
			extra = CMD_NONE;
			if (noisy && (k == span || $urandom_range(0, 3) == 0))
				extra = 3'($urandom_range(1, 7));
			push_tick(extra, 8'($urandom), 1'($urandom), pick_sda(sda_mode));
		end
	endtask

	task automatic random_transfer();
		bit noisy;
		int n_wr;
		int n_rd;
		noisy = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 4) == 0)
			run_command(cmd_t'(3'($urandom_range(1, 5))), 8'($urandom), 1'($urandom),
				$urandom_range(0, 2), noisy);
		else begin
			n_wr = $urandom_range(1, 3);
			n_rd = $urandom_range(0, 3);
			run_command(CMD_START, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
			repeat (n_wr)
				run_command(CMD_WRITE, 8'($urandom), 1'($urandom), $urandom_range(0, 2), noisy);
			repeat (n_rd)
				run_command(CMD_READ, 8'($urandom), 1'($urandom), $urandom_range(0, 2), noisy);
			run_command(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND, noisy);
		end
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 2))
				0: push_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
				1: push_tick(OP_UNUSED_6, 8'($urandom), 1'($urandom), 1'($urandom));
				default: push_tick(OP_UNUSED_7, 8'($urandom), 1'($urandom), 1'($urandom));
			endcase
		end
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || word_held || pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_half_period(logic [15:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		half_ticks = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int phase_start;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_NONE;
		req_ch.tx_byte = '0;
		req_ch.send_ack = 1'b0;
		req_ch.sda_in = 1'b1;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		held_word = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The reset half period, one bus idle command.
		run_command(CMD_IDLEBUS, 8'h00, 1'b0, SDA_RAND, 1'b0);
		wait_drained();

		// A half period of zero counts as one tick.
		write_half_period(16'd0);
		push_tick(OP_UNUSED_6, 8'hFF, 1'b1, 1'b0);
		push_tick(OP_UNUSED_7, 8'h00, 1'b0, 1'b1);
		push_tick(CMD_NONE, 8'h5A, 1'b1, 1'b1);
		run_command(CMD_IDLEBUS, 8'h00, 1'b0, SDA_HIGH, 1'b0);
		run_command(CMD_WRITE, 8'hA5, 1'b0, SDA_LOW, 1'b0);
		run_command(CMD_START, 8'h00, 1'b0, SDA_HIGH, 1'b0);
		run_command(CMD_WRITE, 8'hFF, 1'b1, SDA_LOW, 1'b0);
		run_command(CMD_WRITE, 8'h00, 1'b0, SDA_HIGH, 1'b0);
		run_command(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
		run_command(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 1'b1);
		run_command(CMD_READ, 8'h3C, 1'b1, SDA_RAND, 1'b0);
		run_command(CMD_STOP, 8'h00, 1'b0, SDA_HIGH, 1'b1);
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			write_half_period(p == 0 ? 16'd1 : 16'($urandom_range(2, 3)));
			phase_start = ticks_pushed;
			if (p == 0) begin
				// The result side stalls while words keep coming, so the input backs up.
				random_transfer();
				hold_req++;
			end
			while (ticks_pushed - phase_start < 100)
				random_transfer();
			wait_drained();
		end

		// A short transfer at the end, without idling on either side.
		no_idle = 1'b1;
		write_half_period(16'd2);
		run_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
		run_command(CMD_WRITE, 8'hC3, 1'b0, SDA_RAND, 1'b1);
		run_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
		push_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);
		wait_drained();
		repeat (10) @(posedge clk);

		if (err_count == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_master_byte_engine.sv
tb/sv/tb.sv
